// ===== src/tssu_pkg.sv =====
package tssu_pkg;

    // Sizing of the synchronizer.
    localparam int QUEUE_DEPTH  = 16;
    localparam int SYNC_STREAMS = 3;
    localparam int ALL_STREAMS  = 4;

    // Field widths.
    localparam int STAMP_W = 63;
    localparam int SID_W   = 2;
    localparam int COUNT_W = 32;
    localparam int DISC_W  = 5;
    localparam int SKEW_W  = 40;

    localparam int SIDX_W = SID_W + 1;
    localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam int QIDX_W = $clog2(SYNC_STREAMS);

    // Queue between the front and the back.
    localparam int LINK_DEPTH = 2;
    localparam int LINK_PTR_W = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
    localparam int LINK_CNT_W = $clog2(LINK_DEPTH + 1);

    // Register port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam int REG_LSB    = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - REG_LSB;
    localparam logic [REG_IDX_W-1:0] REG_SKEW_LIMIT = '0;
    localparam logic [SKEW_W-1:0]    SKEW_RESET     = 40'd10000000;

    typedef struct packed {
        logic [SID_W-1:0]   stream_id;
        logic [STAMP_W-1:0] capture_stamp_ns;
        logic [STAMP_W-1:0] arrival_ns;
    } frame_event_t;

    typedef struct packed {
        logic [STAMP_W-1:0] latency_ns;
        logic [COUNT_W-1:0] stream_frames;
        logic               matched;
        logic [STAMP_W-1:0] match_skew_ns;
        logic               skew_warning;
        logic [DISC_W-1:0]  discards_now;
        logic [COUNT_W-1:0] match_total;
        logic [COUNT_W-1:0] discard_total;
    } result_t;

    // Classified event handed from the front to the back.
    typedef struct packed {
        logic               is_sync;
        logic [QIDX_W-1:0]  qidx;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] latency;
        logic [COUNT_W-1:0] frames;
    } cmd_t;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_PUSH    = 6'b000010,
        ST_CHECK   = 6'b000100,
        ST_COMPARE = 6'b001000,
        ST_DECIDE  = 6'b010000,
        ST_EMIT    = 6'b100000
    } back_state_t;

    function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] h);
        logic [HEAD_W-1:0] r;
        if (h == HEAD_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = h + 1'b1;
        end
        return r;
    endfunction

    // Slot that lies fill entries past the head, modulo the queue depth.
    function automatic logic [HEAD_W-1:0] slot_addr(input logic [HEAD_W-1:0] h,
                                                    input logic [FILL_W-1:0] f);
        logic [SUM_W-1:0] s;
        s = SUM_W'(h) + SUM_W'(f);
        if (s >= SUM_W'(QUEUE_DEPTH))
        begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[HEAD_W-1:0];
    endfunction

endpackage

// ===== src/tssu_ram.sv =====
module tssu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tssu_link_fifo.sv =====
module tssu_link_fifo
    import tssu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic empty
);

    cmd_t                  entries_reg [LINK_DEPTH];
    logic [LINK_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [LINK_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LINK_CNT_W-1:0] count_reg, count_next;
    logic                  do_wr, do_rd;

    assign full    = (count_reg == LINK_CNT_W'(LINK_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LINK_PTR_W'(LINK_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LINK_PTR_W'(LINK_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/tssu_front.sv =====
module tssu_front
    import tssu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  frame_event_t frame_event,
    output logic         link_push,
    input  logic         link_full,
    output cmd_t         link_data
);

    logic [COUNT_W-1:0] frames_reg [ALL_STREAMS];
    logic [SIDX_W-1:0]  sidx;
    logic               counted;
    logic [COUNT_W-1:0] frames_new;

    assign full      = link_full;
    assign link_push = push && !link_full;
    assign sidx      = {1'b0, frame_event.stream_id};
    assign counted   = (sidx < SIDX_W'(ALL_STREAMS));

    // Frame count of the addressed stream after this frame.
    always_comb
    begin
        frames_new = '0;
        for (int s = 0; s < ALL_STREAMS; s++)
        begin
            if (sidx == SIDX_W'(s))
            begin
                frames_new = frames_reg[s] + 1'b1;
            end
        end
    end

    always_comb
    begin
        link_data.is_sync = counted && (sidx != '0) && (sidx <= SIDX_W'(SYNC_STREAMS));
        link_data.qidx    = QIDX_W'(sidx - 1'b1);
        link_data.stamp   = frame_event.capture_stamp_ns;
        link_data.frames  = frames_new;
        if (frame_event.arrival_ns > frame_event.capture_stamp_ns)
        begin
            link_data.latency = frame_event.arrival_ns - frame_event.capture_stamp_ns;
        end
        else
        begin
            link_data.latency = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < ALL_STREAMS; s++)
            begin
                frames_reg[s] <= '0;
            end
        end
        else if (link_push && counted)
        begin
            for (int s = 0; s < ALL_STREAMS; s++)
            begin
                if (sidx == SIDX_W'(s))
                begin
                    frames_reg[s] <= frames_new;
                end
            end
        end
    end

endmodule

// ===== src/tssu_back.sv =====
module tssu_back
    import tssu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              link_empty,
    output logic              link_pop,
    input  cmd_t              link_data,
    input  logic [SKEW_W-1:0] skew_limit,
    output logic              empty,
    input  logic              pop,
    output result_t           result
);

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [HEAD_W-1:0]  head_reg [SYNC_STREAMS];
    logic [HEAD_W-1:0]  head_next [SYNC_STREAMS];
    logic [FILL_W-1:0]  fill_reg [SYNC_STREAMS];
    logic [FILL_W-1:0]  fill_next [SYNC_STREAMS];
    logic [COUNT_W-1:0] match_total_reg, match_total_next;
    logic [COUNT_W-1:0] discard_total_reg, discard_total_next;
    logic               matched_reg, matched_next;
    logic               warn_reg, warn_next;
    logic [STAMP_W-1:0] skew_out_reg, skew_out_next;
    logic [DISC_W-1:0]  disc_now_reg, disc_now_next;
    logic [STAMP_W-1:0] lo_reg, lo_next;
    logic [STAMP_W-1:0] hi_reg, hi_next;
    logic [QIDX_W-1:0]  oldest_reg, oldest_next;
    logic               out_valid_reg, out_valid_next;
    result_t            result_reg, result_next;

    logic [SYNC_STREAMS-1:0] ram_we;
    logic [HEAD_W-1:0]       ram_waddr;
    logic [STAMP_W-1:0]      ram_rdata [SYNC_STREAMS];
    logic                    all_filled;
    logic [STAMP_W-1:0]      spread;

    // One stamp memory per synchronized stream, each read at its own head.
    for (genvar g = 0; g < SYNC_STREAMS; g++)
    begin : g_queue
        tssu_ram #(
            .WIDTH (STAMP_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[g]),
            .waddr (ram_waddr),
            .wdata (cmd_reg.stamp),
            .raddr (head_reg[g]),
            .rdata (ram_rdata[g])
        );
    end

    always_comb
    begin
        all_filled = 1'b1;
        for (int q = 0; q < SYNC_STREAMS; q++)
        begin
            if (fill_reg[q] == '0)
            begin
                all_filled = 1'b0;
            end
        end
    end

    assign spread = hi_reg - lo_reg;
    assign empty  = !out_valid_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next         = state_reg;
        cmd_next           = cmd_reg;
        head_next          = head_reg;
        fill_next          = fill_reg;
        match_total_next   = match_total_reg;
        discard_total_next = discard_total_reg;
        matched_next       = matched_reg;
        warn_next          = warn_reg;
        skew_out_next      = skew_out_reg;
        disc_now_next      = disc_now_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        oldest_next        = oldest_reg;
        out_valid_next     = out_valid_reg;
        result_next        = result_reg;
        link_pop           = 1'b0;
        ram_we             = '0;
        ram_waddr          = slot_addr(head_reg[cmd_reg.qidx], fill_reg[cmd_reg.qidx]);

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!link_empty)
                begin
                    link_pop      = 1'b1;
                    cmd_next      = link_data;
                    matched_next  = 1'b0;
                    warn_next     = 1'b0;
                    skew_out_next = '0;
                    disc_now_next = '0;
                    state_next    = link_data.is_sync ? ST_PUSH : ST_EMIT;
                end
            end
            ST_PUSH:
            begin
                // A full queue gives up its head to the new stamp.
                ram_we[cmd_reg.qidx] = 1'b1;
                if (fill_reg[cmd_reg.qidx] == FILL_W'(QUEUE_DEPTH))
                begin
                    head_next[cmd_reg.qidx] = head_inc(head_reg[cmd_reg.qidx]);
                    discard_total_next      = discard_total_reg + 1'b1;
                    disc_now_next           = disc_now_reg + 1'b1;
                end
                else
                begin
                    fill_next[cmd_reg.qidx] = fill_reg[cmd_reg.qidx] + 1'b1;
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = all_filled ? ST_COMPARE : ST_EMIT;
            end
            ST_COMPARE:
            begin
                lo_next     = ram_rdata[0];
                hi_next     = ram_rdata[0];
                oldest_next = '0;
                for (int k = 1; k < SYNC_STREAMS; k++)
                begin
                    if (ram_rdata[k] < lo_next)
                    begin
                        lo_next     = ram_rdata[k];
                        oldest_next = QIDX_W'(k);
                    end
                    if (ram_rdata[k] > hi_next)
                    begin
                        hi_next = ram_rdata[k];
                    end
                end
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (spread > STAMP_W'(skew_limit))
                begin
                    head_next[oldest_reg] = head_inc(head_reg[oldest_reg]);
                    fill_next[oldest_reg] = fill_reg[oldest_reg] - 1'b1;
                    discard_total_next    = discard_total_reg + 1'b1;
                    disc_now_next         = disc_now_reg + 1'b1;
                    warn_next             = 1'b1;
                end
                else
                begin
                    for (int q = 0; q < SYNC_STREAMS; q++)
                    begin
                        head_next[q] = head_inc(head_reg[q]);
                        fill_next[q] = fill_reg[q] - 1'b1;
                    end
                    match_total_next = match_total_reg + 1'b1;
                    matched_next     = 1'b1;
                    skew_out_next    = spread;
                end
                state_next = ST_CHECK;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    result_next.latency_ns    = cmd_reg.latency;
                    result_next.stream_frames = cmd_reg.frames;
                    result_next.matched       = matched_reg;
                    result_next.match_skew_ns = skew_out_reg;
                    result_next.skew_warning  = warn_reg;
                    result_next.discards_now  = disc_now_reg;
                    result_next.match_total   = match_total_reg;
                    result_next.discard_total = discard_total_reg;
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            match_total_reg   <= '0;
            discard_total_reg <= '0;
            out_valid_reg     <= 1'b0;
            for (int q = 0; q < SYNC_STREAMS; q++)
            begin
                head_reg[q] <= '0;
                fill_reg[q] <= '0;
            end
        end
        else
        begin
            state_reg         <= state_next;
            match_total_reg   <= match_total_next;
            discard_total_reg <= discard_total_next;
            out_valid_reg     <= out_valid_next;
            head_reg          <= head_next;
            fill_reg          <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        matched_reg  <= matched_next;
        warn_reg     <= warn_next;
        skew_out_reg <= skew_out_next;
        disc_now_reg <= disc_now_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        oldest_reg   <= oldest_next;
        result_reg   <= result_next;
    end

endmodule

// ===== src/timestamp_triplet_synchronizer_unit.sv =====
// Timestamp triplet synchronizer.
// Frame events enter through a queue-style port: a transfer happens on a clock edge
// with push high and full low. Results leave the same way: the oldest result sits on
// the result port while empty is low and is taken by a transfer with pop high.
// Every event yields exactly one result, in event order.
// The front classifies an event, updates its stream's frame count and computes the
// latency; a two-entry queue carries it to the back, which, for a synchronized stream,
// pushes the stamp into its stream queue and runs the head comparison loop.
// From input transfer to a visible result, an event passes the link queue and the IDLE
// state of the back; a synchronized one then passes PUSH, CHECK and one COMPARE, DECIDE
// and CHECK round per head comparison (a skew drop or a match); then EMIT loads the
// result register. The back takes no new event until EMIT, and its read, compare and
// decide loop over the stamp memories runs up to 31 comparisons per event.
// Reset empties all stamp queues, clears every counter and loads the default skew
// limit. When the receiver stalls, the result register holds the result, the back
// waits on the next one and the link queue fills, after which full rises.
// The skew limit is written through the APB port at byte address 0.
module timestamp_triplet_synchronizer_unit
    import tssu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  frame_event_t          frame_event,
    output logic                  empty,
    input  logic                  pop,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [SKEW_W-1:0] skew_limit_reg, skew_limit_next;
    logic              link_push, link_full, link_pop, link_empty;
    cmd_t              link_wr_data, link_rd_data;
    logic              reg_hit;

    // Register access; the port never inserts wait states.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:REG_LSB] == REG_SKEW_LIMIT);

    always_comb
    begin
        skew_limit_next = skew_limit_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            skew_limit_next = pwdata[SKEW_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_hit)
        begin
            prdata = APB_DATA_W'(skew_limit_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skew_limit_reg <= SKEW_RESET;
        end
        else
        begin
            skew_limit_reg <= skew_limit_next;
        end
    end

    // The front takes events as long as the link queue has room.
    tssu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .frame_event (frame_event),
        .link_push   (link_push),
        .link_full   (link_full),
        .link_data   (link_wr_data)
    );

    tssu_link_fifo u_link (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (link_push),
        .wr_data (link_wr_data),
        .full    (link_full),
        .rd_en   (link_pop),
        .rd_data (link_rd_data),
        .empty   (link_empty)
    );

    // The back owns the stamp queues, the match and discard totals and the
    // result register.
    tssu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_empty (link_empty),
        .link_pop   (link_pop),
        .link_data  (link_rd_data),
        .skew_limit (skew_limit_reg),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ===== src/tssu_checker.sv =====
module tssu_checker
    import tssu_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    // A waiting result stays until it is taken.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result withdrawn before transfer");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result))
        else $error("waiting result changed");

    // Only a matched triplet reports a spread.
    a_skew_only_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.matched) |-> (result.match_skew_ns == '0))
        else $error("spread reported without a match");

    // A skew warning always comes with at least one discarded stamp.
    a_warning_discards: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.skew_warning) |-> (result.discards_now != '0))
        else $error("skew warning without a discard");

endmodule

bind timestamp_triplet_synchronizer_unit tssu_checker u_checker (.*);

// ===== verif/timestamp_triplet_synchronizer_unit_tb.sv =====
module timestamp_triplet_synchronizer_unit_tb;
    import tssu_pkg::*;

    // A stretch this long with no transfer on either side means the block is stuck.
    localparam int WATCHDOG_LIMIT = 3000;
    // Quiet cycles after the last result, before a register write or the end.
    localparam int SETTLE_CYCLES = 8;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
    localparam logic [SKEW_W-1:0]  SKEW_MAX  = '1;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    frame_event_t          frame_event = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    result_t               result;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    timestamp_triplet_synchronizer_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .frame_event (frame_event),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Frame events waiting to be offered to the block, and the results that the
    // accepted ones must produce, oldest first.
    frame_event_t queued_frames[$];
    result_t      predicted_results[$];

    // Our own copy of the synchronizer state. The stamp queues are kept as rings
    // so that head and fill track the block's bookkeeping one to one.
    logic [SKEW_W-1:0]  skew_limit = SKEW_RESET;
    logic [STAMP_W-1:0] stamp_ring [SYNC_STREAMS][QUEUE_DEPTH];
    int                 ring_head [SYNC_STREAMS];
    int                 ring_fill [SYNC_STREAMS];
    logic [COUNT_W-1:0] frame_tally [ALL_STREAMS];
    logic [COUNT_W-1:0] match_tally;
    logic [COUNT_W-1:0] discard_tally;

    // Run statistics for the closing summary.
    int frames_sent = 0;
    int triplets_seen = 0;
    int skew_drops = 0;
    int overflow_drops = 0;
    int limit_settings = 0;
    int mismatches = 0;

    // Idling control: both sides stall in random bursts while this is set.
    bit gaps_on = 1'b1;
    int send_gap = 0;
    int recv_gap = 0;
    int quiet_cycles = 0;

    // Base time of the current frame round in the random part.
    logic [STAMP_W-1:0] round_base;

    function automatic void retire_head(int q);
        ring_head[q] = (ring_head[q] + 1) % QUEUE_DEPTH;
        ring_fill[q] = ring_fill[q] - 1;
    endfunction

    // Works out the result of one accepted frame event and advances the state.
    function automatic result_t predict_frame_result(frame_event_t ev);
        result_t            r;
        int                 q;
        int                 k;
        int                 oldest;
        bit                 ready;
        logic [STAMP_W-1:0] lo;
        logic [STAMP_W-1:0] hi;
        logic [STAMP_W-1:0] v;
        r = '0;
        if (ev.arrival_ns > ev.capture_stamp_ns)
        begin
            r.latency_ns = ev.arrival_ns - ev.capture_stamp_ns;
        end
        frame_tally[ev.stream_id] = frame_tally[ev.stream_id] + 1'b1;
        r.stream_frames = frame_tally[ev.stream_id];
        if (ev.stream_id >= 1 && int'(ev.stream_id) - 1 < SYNC_STREAMS)
        begin
            q = int'(ev.stream_id) - 1;
            // A full queue makes room by giving up its oldest stamp.
            if (ring_fill[q] >= QUEUE_DEPTH)
            begin
                retire_head(q);
                discard_tally = discard_tally + 1'b1;
                r.discards_now = r.discards_now + 1'b1;
                overflow_drops++;
            end
            stamp_ring[q][(ring_head[q] + ring_fill[q]) % QUEUE_DEPTH] = ev.capture_stamp_ns;
            ring_fill[q] = ring_fill[q] + 1;
            // Compare heads for as long as every queue has one. Too wide a spread
            // costs the oldest head (lowest queue on a tie); otherwise all pop.
            do
            begin
                ready = 1'b1;
                for (k = 0; k < SYNC_STREAMS; k++)
                begin
                    if (ring_fill[k] == 0)
                    begin
                        ready = 1'b0;
                    end
                end
                if (ready)
                begin
                    oldest = 0;
                    lo = stamp_ring[0][ring_head[0]];
                    hi = lo;
                    for (k = 1; k < SYNC_STREAMS; k++)
                    begin
                        v = stamp_ring[k][ring_head[k]];
                        if (v < lo)
                        begin
                            lo = v;
                            oldest = k;
                        end
                        if (v > hi)
                        begin
                            hi = v;
                        end
                    end
                    if (hi - lo > STAMP_W'(skew_limit))
                    begin
                        retire_head(oldest);
                        discard_tally = discard_tally + 1'b1;
                        r.discards_now = r.discards_now + 1'b1;
                        r.skew_warning = 1'b1;
                        skew_drops++;
                    end
                    else
                    begin
                        for (k = 0; k < SYNC_STREAMS; k++)
                        begin
                            retire_head(k);
                        end
                        match_tally = match_tally + 1'b1;
                        r.matched = 1'b1;
                        r.match_skew_ns = hi - lo;
                        triplets_seen++;
                    end
                end
            end
            while (ready);
        end
        r.match_total = match_tally;
        r.discard_total = discard_tally;
        return r;
    endfunction

    function automatic void compare_field(string field, logic [STAMP_W-1:0] want,
                                          logic [STAMP_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result(result_t got);
        result_t want;
        if (predicted_results.size() == 0)
        begin
            $display("%0t: result with no frame event outstanding, actual %h", $time, got);
            mismatches++;
            return;
        end
        want = predicted_results[0];
        predicted_results.delete(0);
        compare_field("latency_ns", want.latency_ns, got.latency_ns);
        compare_field("stream_frames", want.stream_frames, got.stream_frames);
        compare_field("matched", want.matched, got.matched);
        compare_field("match_skew_ns", want.match_skew_ns, got.match_skew_ns);
        compare_field("skew_warning", want.skew_warning, got.skew_warning);
        compare_field("discards_now", want.discards_now, got.discards_now);
        compare_field("match_total", want.match_total, got.match_total);
        compare_field("discard_total", want.discard_total, got.discard_total);
    endfunction

    // Driver. The previous offer is judged on the values from before the edge; a
    // new frame is offered only once the last one has made its transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            frame_event <= '0;
            send_gap = 0;
        end
        else
        begin
            if (push && !full)
            begin
                predicted_results = {predicted_results, predict_frame_result(frame_event)};
                frames_sent++;
            end
            if (!push || !full)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    push <= 1'b0;
                end
                else if (queued_frames.size() != 0)
                begin
                    frame_event <= queued_frames[0];
                    queued_frames.delete(0);
                    push <= 1'b1;
                    // Sometimes hold off after this frame goes through.
                    if (gaps_on && $urandom_range(0, 5) == 0)
                    begin
                        send_gap = $urandom_range(1, 15);
                    end
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor. Takes results whenever it is not in a stall burst.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                check_result(result);
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                pop <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(0, 14);
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, predicted_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [STAMP_W-1:0] rand_stamp();
        return STAMP_W'({$urandom, $urandom});
    endfunction

    function automatic logic [STAMP_W-1:0] rand_upto(logic [STAMP_W-1:0] bound);
        return STAMP_W'({1'b0, rand_stamp()} % ({1'b0, bound} + 64'd1));
    endfunction

    // Arrival is usually a little after capture, sometimes before it (the latency
    // must then clamp to zero), sometimes anywhere at all.
    function automatic logic [STAMP_W-1:0] arrival_after(logic [STAMP_W-1:0] stamp);
        case ($urandom_range(0, 7))
            0: return rand_stamp();
            1: return stamp - STAMP_W'($urandom_range(1, 1000));
            default: return stamp + STAMP_W'($urandom_range(0, 5000000));
        endcase
    endfunction

    // Offset of one stream's stamp from the round base. Mostly within half the
    // limit, so a full round matches; now and then right on the limit or one past.
    function automatic logic [STAMP_W-1:0] jitter_for(logic [STAMP_W-1:0] lim);
        case ($urandom_range(0, 9))
            6: return lim;
            7: return '0;
            8: return lim + 1'b1;
            9: return rand_upto(2 * lim + 2);
            default: return rand_upto(lim >> 1);
        endcase
    endfunction

    function automatic void queue_frame(int sid, logic [STAMP_W-1:0] stamp,
                                        logic [STAMP_W-1:0] arrival);
        frame_event_t ev;
        ev.stream_id = SID_W'(sid);
        ev.capture_stamp_ns = stamp;
        ev.arrival_ns = arrival;
        queued_frames = {queued_frames, ev};
    endfunction

    // One camera round: the given number of synchronized streams in shuffled
    // order around a common base time, with an occasional count-only frame.
    function automatic void queue_round(logic [STAMP_W-1:0] lim, int streams_used);
        int                 order [SYNC_STREAMS];
        int                 k;
        int                 j;
        int                 t;
        logic [STAMP_W-1:0] stamp;
        for (k = 0; k < SYNC_STREAMS; k++)
        begin
            order[k] = k + 1;
        end
        for (k = SYNC_STREAMS - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (k = 0; k < streams_used; k++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                stamp = round_base + STAMP_W'($urandom_range(0, 1000));
                queue_frame(0, stamp, arrival_after(stamp));
            end
            stamp = round_base + jitter_for(lim);
            queue_frame(order[k], stamp, arrival_after(stamp));
        end
        round_base = round_base + rand_upto(3 * lim + 100) + 1'b1;
        if (round_base[STAMP_W-1 -: 2] != 2'b00)
        begin
            round_base = rand_upto(STAMP_W'(1) << 40);
        end
    endfunction

    // Random part of one phase: mostly complete rounds, some rounds missing a
    // stream (which forces skew drops later), floods of one stream that overrun
    // its queue, and fully random frames.
    function automatic void queue_random_phase(int goal);
        logic [STAMP_W-1:0] lim;
        logic [STAMP_W-1:0] step;
        int                 pick;
        int                 sid;
        int                 n;
        int                 k;
        lim = STAMP_W'(skew_limit);
        while (queued_frames.size() < goal)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                queue_round(lim, SYNC_STREAMS);
            end
            else if (pick < 16)
            begin
                queue_round(lim, $urandom_range(1, SYNC_STREAMS - 1));
            end
            else if (pick == 16)
            begin
                sid = $urandom_range(1, SYNC_STREAMS);
                n = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 4);
                step = rand_upto(lim + 100) + 1'b1;
                for (k = 0; k < n; k++)
                begin
                    queue_frame(sid, round_base, arrival_after(round_base));
                    round_base = round_base + step;
                end
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: queue_frame($urandom_range(0, 3), '0, STAMP_MAX);
                    1: queue_frame($urandom_range(0, 3), STAMP_MAX, rand_stamp());
                    default: queue_frame($urandom_range(0, 3), rand_stamp(), rand_stamp());
                endcase
            end
        end
    endfunction

    // Register write: setup cycle, then access cycle until pready. Ends on a
    // falling edge so that the caller never races the driver.
    task automatic write_skew_limit(input logic [SKEW_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(REG_SKEW_LIMIT) << REG_LSB;
        pwdata <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        skew_limit = value;
        limit_settings++;
        @(negedge clk);
    endtask

    // Waits until every queued frame has gone in and every result has come out,
    // then lets the block settle.
    task automatic wait_for_drain();
        while (queued_frames.size() != 0 || push || predicted_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [STAMP_W-1:0] lim;
        for (int q = 0; q < SYNC_STREAMS; q++)
        begin
            ring_head[q] = 0;
            ring_fill[q] = 0;
            for (int e = 0; e < QUEUE_DEPTH; e++)
            begin
                stamp_ring[q][e] = '0;
            end
        end
        for (int s = 0; s < ALL_STREAMS; s++)
        begin
            frame_tally[s] = '0;
        end
        match_tally = '0;
        discard_tally = '0;
        round_base = rand_upto(STAMP_W'(1) << 40);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset skew limit.
        lim = STAMP_W'(SKEW_RESET);
        // Count-only stream: largest latency, a negative one that clamps, zero.
        queue_frame(0, '0, STAMP_MAX);
        queue_frame(0, STAMP_MAX, '0);
        queue_frame(0, 63'd12345, 63'd12345);
        // A triplet whose spread is exactly the limit still matches.
        queue_frame(1, 63'd1000, 63'd2000);
        queue_frame(2, 63'd1000 + lim, 63'd1000 + lim);
        queue_frame(3, 63'd1000 + (lim >> 1), rand_stamp());
        // One past the limit with two equal oldest heads: the lowest queue goes,
        // then the next oldest, then the rest match with no spread.
        queue_frame(1, 63'd5, 63'd50);
        queue_frame(2, 63'd5, 63'd50);
        queue_frame(3, 63'd6 + lim, 63'd50);
        queue_frame(1, 63'd6 + lim, 63'd50);
        queue_frame(2, 63'd6 + lim, lim + lim);
        // Three stale stamps on the first queue are dropped in one event.
        queue_frame(1, 63'd0, 63'd10);
        queue_frame(1, 63'd1, 63'd10);
        queue_frame(1, 63'd2, 63'd10);
        queue_frame(2, 63'd50000000, 63'd50000000);
        queue_frame(3, 63'd50000000, 63'd50000001);
        queue_frame(1, 63'd50000000 + lim, 63'd60000000);
        // Largest stamps match; then the widest spread with a tie on the low side.
        queue_frame(1, STAMP_MAX, STAMP_MAX);
        queue_frame(2, STAMP_MAX, '0);
        queue_frame(3, STAMP_MAX, STAMP_MAX);
        queue_frame(1, '0, STAMP_MAX);
        queue_frame(2, STAMP_MAX, STAMP_MAX);
        queue_frame(3, '0, '0);
        wait_for_drain();

        // Random phases, each under a different skew limit: zero, the largest,
        // a small one, any value, and back to the reset value with no idling.
        write_skew_limit('0);
        queue_random_phase(375);
        wait_for_drain();

        write_skew_limit(SKEW_MAX);
        queue_random_phase(375);
        wait_for_drain();

        write_skew_limit(SKEW_W'($urandom_range(1, 2000)));
        queue_random_phase(375);
        wait_for_drain();

        write_skew_limit({8'($urandom_range(0, 255)), 32'($urandom)});
        queue_random_phase(375);
        wait_for_drain();

        write_skew_limit(SKEW_RESET);
        gaps_on = 1'b0;
        queue_random_phase(375);
        wait_for_drain();
        repeat (20) @(negedge clk);

        $display("Sent %0d frame events under %0d written skew limits besides the reset one.",
                 frames_sent, limit_settings);
        $display("Saw %0d triplet matches, %0d skew drops and %0d queue overflow drops.",
                 triplets_seen, skew_drops, overflow_drops);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
